>>> rtl/cbb_pkg.sv
package cbb_pkg;

  localparam int DEPTH     = 1024;
  localparam int MAX_BURST = 64;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_W = $clog2(DEPTH + 1);
  localparam int CNT_W = 7;
  localparam int CFG_W = 11;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CAP_W-1:0] cap_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_DISCARD = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] data_byte;
    logic       write_last;
    cnt_t       count;
  } req_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       byte_valid;
    logic       accepted;
    cnt_t       dropped_count;
    logic       last;
    cap_t       bytes_used;
    logic       is_full;
    logic       is_empty;
    cap_t       contiguous_readable;
  } rsp_t;

  function automatic cap_t used_bytes(ptr_t h, ptr_t t, logic hd, cap_t cap);
    if (h > t) return CAP_W'(h) - CAP_W'(t);
    if (t > h) return cap - (CAP_W'(t) - CAP_W'(h));
    return hd ? cap : '0;
  endfunction

  function automatic cap_t contig_bytes(ptr_t h, ptr_t t, logic hd, cap_t cap);
    if (t > h) return cap - CAP_W'(t);
    if (h > t) return CAP_W'(h) - CAP_W'(t);
    return hd ? (cap - CAP_W'(t)) : '0;
  endfunction

  // next slot, wrapping at the active capacity
  function automatic ptr_t advance(ptr_t p, cap_t cap);
    cap_t n;
    n = CAP_W'(p) + CAP_W'(1);
    return (n >= cap) ? '0 : n[PTR_W-1:0];
  endfunction

  function automatic cap_t clamp_cap(logic [CFG_W-1:0] v);
    if (v == '0) return CAP_W'(1);
    if (CAP_W'(v) > CAP_W'(DEPTH) || (CFG_W > CAP_W && (v >> CAP_W) != '0))
      return CAP_W'(DEPTH);
    return CAP_W'(v);
  endfunction

endpackage

>>> rtl/circular_byte_buffer.sv
// Every result appears on the cycle after the step that makes it.
// Write, discard, clear and empty reads take one request per cycle while not busy.
// A read popping more than one byte holds busy until its last byte pops: one byte per cycle
// through the single registered read port of the byte store.
// Reset (rst, synchronous): pointers and the not-empty flag go to zero, capacity
// to DEPTH; store contents are left as they are. Results cannot be stalled.
module circular_byte_buffer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  cbb_pkg::req_t                 request,
  output logic                          busy,
  input  logic                          cfg_we,
  input  logic [cbb_pkg::CFG_W-1:0]     cfg_data,
  output logic                          done,
  output cbb_pkg::rsp_t                 result
);
  import cbb_pkg::*;

  typedef enum logic {ST_IDLE, ST_READ} state_t;

  // Byte store: one write port at head, one registered read port at tail.
  logic [7:0] byte_store [DEPTH];
  logic [7:0] rd_q;

  state_t state, state_next;
  ptr_t   head, head_next;
  ptr_t   tail, tail_next;
  logic   holds, holds_next;
  cap_t   cap, cap_next;
  cnt_t   remaining, remaining_next;   // bytes still to pop for the current read

  // registered result fields
  logic   res_strobe, res_strobe_next;
  logic   res_bv, res_bv_next;
  logic   res_acc, res_acc_next;
  cnt_t   res_drop, res_drop_next;
  logic   res_last, res_last_next;
  cap_t   res_used, res_contig;
  logic   res_full, res_empty;

  logic   mem_we;
  logic   pop, pop_last;
  cap_t   used_cur;
  cnt_t   cnt_sat, avail;
  cap_t   disc_sum;

  // Status available now, and how many bytes this request may move.
  always_comb begin
    used_cur = used_bytes(head, tail, holds, cap);
    cnt_sat  = (request.count > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST) : request.count;
    avail    = (used_cur < CAP_W'(cnt_sat)) ? used_cur[CNT_W-1:0] : cnt_sat;
    disc_sum = CAP_W'(tail) + CAP_W'(avail);
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    holds_next      = holds;
    cap_next        = cap;
    remaining_next  = remaining;
    res_strobe_next = 1'b0;
    res_bv_next     = 1'b0;
    res_acc_next    = 1'b0;
    res_drop_next   = '0;
    res_last_next   = 1'b0;
    mem_we          = 1'b0;
    pop             = 1'b0;
    pop_last        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          res_strobe_next = 1'b1;
          case (request.opcode)
            OP_WRITE: begin
              res_last_next = request.write_last;
              // drop the byte when pointers meet on a full buffer
              if (!(head == tail && holds)) begin
                mem_we       = 1'b1;
                head_next    = advance(head, cap);
                holds_next   = 1'b1;
                res_acc_next = 1'b1;
              end
            end
            OP_READ: begin
              if (avail == '0) begin
                res_last_next = 1'b1;
              end else begin
                // first byte pops in the request cycle itself
                pop            = 1'b1;
                pop_last       = (avail == CNT_W'(1));
                remaining_next = avail - CNT_W'(1);
                if (avail != CNT_W'(1)) state_next = ST_READ;
              end
            end
            OP_DISCARD: begin
              res_last_next = 1'b1;
              res_drop_next = avail;
              if (avail != '0) begin
                // tail + avail stays below twice the capacity: one subtract wraps it
                tail_next = (disc_sum >= cap) ? PTR_W'(disc_sum - cap) : PTR_W'(disc_sum);
                if (tail_next == head) holds_next = 1'b0;
              end
            end
            OP_CLEAR: begin
              res_last_next = 1'b1;
              head_next     = '0;
              tail_next     = '0;
              holds_next    = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        pop            = 1'b1;
        pop_last       = (remaining == CNT_W'(1));
        remaining_next = remaining - CNT_W'(1);
        if (remaining == CNT_W'(1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase

    if (pop) begin
      tail_next       = advance(tail, cap);
      if (tail_next == head) holds_next = 1'b0;
      res_strobe_next = 1'b1;
      res_bv_next     = 1'b1;
      res_last_next   = pop_last;
    end

    // capacity changes only while empty; pointers return to slot zero
    if (cfg_we && !holds) begin
      cap_next  = clamp_cap(cfg_data);
      head_next = '0;
      tail_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_store[head] <= request.data_byte;
    end
    rd_q <= byte_store[tail];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      tail       <= '0;
      holds      <= 1'b0;
      cap        <= CAP_W'(DEPTH);
      res_strobe <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      holds      <= holds_next;
      cap        <= cap_next;
      res_strobe <= res_strobe_next;
    end
    remaining  <= remaining_next;
    res_bv     <= res_bv_next;
    res_acc    <= res_acc_next;
    res_drop   <= res_drop_next;
    res_last   <= res_last_next;
    // status is taken after the step that made this result
    res_used   <= used_bytes(head_next, tail_next, holds_next, cap_next);
    res_contig <= contig_bytes(head_next, tail_next, holds_next, cap_next);
    res_full   <= (head_next == tail_next) && holds_next;
    res_empty  <= !holds_next;
  end

  assign busy = (state == ST_READ);
  assign done = res_strobe;

  always_comb begin
    result.read_byte           = res_bv ? rd_q : 8'h00;
    result.byte_valid          = res_bv;
    result.accepted            = res_acc;
    result.dropped_count       = res_drop;
    result.last                = res_last;
    result.bytes_used          = res_used;
    result.is_full             = res_full;
    result.is_empty            = res_empty;
    result.contiguous_readable = res_contig;
  end

endmodule

>>> rtl/cbb_checker.sv
module cbb_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input cbb_pkg::rsp_t result
);
  import cbb_pkg::*;

  // each accepted request answers on the next cycle
  a_req_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done) else $error("no result after request");

  // each busy cycle pops one byte
  a_busy_pop: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && result.byte_valid) else $error("read burst gap");

  // an unfinished read keeps producing bytes
  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    done && result.byte_valid && !result.last |=> done && result.byte_valid)
    else $error("read burst ended early");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.is_full && result.is_empty)) else $error("full and empty");

  a_byte_fields: assert property (@(posedge clk) disable iff (rst)
    done && result.byte_valid |-> !result.accepted && result.dropped_count == '0)
    else $error("read result carries write or discard fields");

endmodule

bind circular_byte_buffer cbb_checker u_cbb_checker (.*);

>>> tb/circular_byte_buffer_test.sv
`timescale 1ns / 100ps

// Byte ring buffer: command requests in, one status reply per cycle out.
// A shadow copy of the ring (store, head, tail, holding flag, capacity) works
// out the replies for each accepted request; the reply watcher pops them in
// order and compares field by field.
module circular_byte_buffer_test;
  import cbb_pkg::*;

  logic           clk;
  logic           rst = 1'b1;
  logic           start = 1'b0;
  req_t           request = '0;
  logic           busy;
  logic           cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic           done;
  rsp_t           result;

  circular_byte_buffer dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .request  (request),
    .busy     (busy),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow ring
  // ---------------------------------------------------------------------------
  logic [7:0] shadow_bytes [DEPTH];
  int         ring_head = 0;     // next slot to write
  int         ring_tail = 0;     // next slot to read
  bit         ring_holding = 0;  // set: equal pointers mean full
  int         cap_now = DEPTH;

  rsp_t       owed_replies [$];  // replies not yet seen, oldest first
  rsp_t       fresh_replies [$]; // replies of the request just accepted

  int         fault_count = 0;
  int         requests_sent = 0;
  int         replies_checked = 0;
  int         settings_used = 0;

  // Hard stop: far beyond the slowest legal run (under two hundred requests,
  // at most 64 replies each, with random idle gaps between them).
  initial begin
    #1_000_000;
    $display("%0t: timed out, %0d replies still owed", $time, owed_replies.size());
    $display("status: fail");
    $finish;
  end

  function automatic int ring_used();
    if (ring_head > ring_tail) return ring_head - ring_tail;
    if (ring_tail > ring_head) return cap_now - (ring_tail - ring_head);
    return ring_holding ? cap_now : 0;
  endfunction

  // bytes readable from the tail before the wrap or the head
  function automatic int ring_run();
    if (ring_tail > ring_head) return cap_now - ring_tail;
    if (ring_head > ring_tail) return ring_head - ring_tail;
    return ring_holding ? cap_now - ring_tail : 0;
  endfunction

  function automatic int ring_next(input int p);
    return (p + 1 >= cap_now) ? 0 : p + 1;
  endfunction

  // reply carrying the ring status as it stands now
  function automatic rsp_t status_reply(input int rb, input bit valid, input bit acc,
                                        input int dropped, input bit fin);
    rsp_t r;
    r.read_byte           = 8'(rb);
    r.byte_valid          = valid;
    r.accepted            = acc;
    r.dropped_count       = cnt_t'(dropped);
    r.last                = fin;
    r.bytes_used          = cap_t'(ring_used());
    r.is_full             = (ring_head == ring_tail) && ring_holding;
    r.is_empty            = !ring_holding;
    r.contiguous_readable = cap_t'(ring_run());
    return r;
  endfunction

  // Applies one accepted request to the shadow ring, leaving its replies
  // in fresh_replies.
  function automatic void ring_apply(input req_t rq);
    int want_n;
    int avail;
    int i;
    int b;
    want_n = (rq.count > MAX_BURST) ? MAX_BURST : int'(rq.count);
    case (rq.opcode)
      OP_WRITE: begin
        if (ring_head == ring_tail && ring_holding) begin
          fresh_replies.push_back(status_reply(0, 0, 0, 0, rq.write_last));
        end else begin
          shadow_bytes[ring_head] = rq.data_byte;
          ring_head = ring_next(ring_head);
          ring_holding = 1;
          fresh_replies.push_back(status_reply(0, 0, 1, 0, rq.write_last));
        end
      end
      OP_READ: begin
        avail = ring_used();
        if (avail > want_n) avail = want_n;
        if (avail == 0) begin
          fresh_replies.push_back(status_reply(0, 0, 0, 0, 1));
        end
        for (i = 0; i < avail; i++) begin
          b = shadow_bytes[ring_tail];
          ring_tail = ring_next(ring_tail);
          if (ring_tail == ring_head) ring_holding = 0;
          fresh_replies.push_back(status_reply(b, 1, 0, 0, i == avail - 1));
        end
      end
      OP_DISCARD: begin
        avail = ring_used();
        if (avail > want_n) avail = want_n;
        if (avail > 0) begin
          ring_tail = (ring_tail + avail) % cap_now;
          // emptied by the discard: drop the holding flag too
          if (ring_tail == ring_head) ring_holding = 0;
        end
        fresh_replies.push_back(status_reply(0, 0, 0, avail, 1));
      end
      default: begin
        ring_head = 0;
        ring_tail = 0;
        ring_holding = 0;
        fresh_replies.push_back(status_reply(0, 0, 0, 0, 1));
      end
    endcase
  endfunction

  // capacity write: ignored while bytes are held, else saturated to 1..DEPTH
  function automatic void ring_set_capacity(input int value);
    int v;
    v = value & 'h7FF;
    if (ring_holding) return;
    cap_now = (v == 0) ? 1 : (v > DEPTH) ? DEPTH : v;
    ring_head = 0;
    ring_tail = 0;
  endfunction

  function automatic req_t cmd(input opcode_t op, input int data, input bit wl,
                               input int cnt);
    req_t r;
    r.opcode     = op;
    r.data_byte  = 8'(data);
    r.write_last = wl;
    r.count      = cnt_t'(cnt);
    return r;
  endfunction

  function automatic rsp_t status_of(input int rb, input bit valid, input bit acc,
                                     input int dropped, input bit fin, input int used,
                                     input bit full, input bit empty, input int run);
    rsp_t r;
    r.read_byte           = 8'(rb);
    r.byte_valid          = valid;
    r.accepted            = acc;
    r.dropped_count       = cnt_t'(dropped);
    r.last                = fin;
    r.bytes_used          = cap_t'(used);
    r.is_full             = full;
    r.is_empty            = empty;
    r.contiguous_readable = cap_t'(run);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Reply watcher. Replies cannot be held off, so every done pulse is taken.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fault_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst && done) begin
      if (owed_replies.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected reply, expected none, got %h", $time, result);
      end else begin
        want = owed_replies.pop_front();
        replies_checked++;
        check_field("read_byte", want.read_byte, result.read_byte);
        check_field("byte_valid", want.byte_valid, result.byte_valid);
        check_field("accepted", want.accepted, result.accepted);
        check_field("dropped_count", want.dropped_count, result.dropped_count);
        check_field("last", want.last, result.last);
        check_field("bytes_used", want.bytes_used, result.bytes_used);
        check_field("is_full", want.is_full, result.is_full);
        check_field("is_empty", want.is_empty, result.is_empty);
        check_field("contiguous_readable", want.contiguous_readable,
                    result.contiguous_readable);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side. Each task returns on a rising edge; start stays high after
  // an accepted request so requests can follow back to back.
  // ---------------------------------------------------------------------------

  // Sends one request; a typed reply, when given, replaces the shadow's own.
  task automatic issue(input req_t rq, input bit typed, input rsp_t want);
    start   <= 1'b1;
    request <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    fresh_replies.delete();
    ring_apply(rq);
    if (typed) fresh_replies[0] = want;
    foreach (fresh_replies[i]) owed_replies.push_back(fresh_replies[i]);
    requests_sent++;
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // random idle burst, none in quiet stretches
  task automatic gap(input bit quiet);
    if (!quiet && $urandom_range(0, 3) == 0) pause($urandom_range(1, 8));
  endtask

  // hold requests until every owed reply is in
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (owed_replies.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input int value);
    cfg_we   <= 1'b1;
    cfg_data <= CFG_W'(value);
    @(posedge clk);
    ring_set_capacity(value);
    cfg_we   <= 1'b0;
    settings_used++;
  endtask

  // Mostly a write burst followed by a read or discard of about that size,
  // otherwise a lone request with any field values, or a clear.
  task automatic random_sequence(input bit quiet);
    int kind;
    int k;
    int i;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      k = $urandom_range(1, (cap_now + 2 < 12) ? cap_now + 2 : 12);
      for (i = 0; i < k; i++) begin
        issue(cmd(OP_WRITE, $urandom_range(0, 255), i == k - 1,
                  $urandom_range(0, 127)), 0, '0);
        gap(quiet);
      end
      issue(cmd(($urandom_range(0, 2) == 0) ? OP_DISCARD : OP_READ,
                $urandom_range(0, 255), 1'($urandom_range(0, 1)),
                $urandom_range(1, k + 1)), 0, '0);
    end else if (kind <= 8) begin
      issue(cmd(opcode_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                1'($urandom_range(0, 1)), $urandom_range(0, 127)), 0, '0);
    end else begin
      issue(cmd(OP_CLEAR, $urandom_range(0, 255), 1'($urandom_range(0, 1)),
                $urandom_range(0, 127)), 0, '0);
    end
    gap(quiet);
  endtask

  // One capacity setting. keep leaves held bytes in place, so the write is
  // ignored if any; long adds a burst past MAX_BURST, then an oversized read.
  task automatic run_phase(input int value, input int budget, input bit quiet,
                           input bit keep, input bit long);
    int target;
    int i;
    settle();
    if (!keep && ring_holding) begin
      issue(cmd(OP_CLEAR, 0, 1, 0), 0, '0);
      settle();
    end
    repeat (2) @(posedge clk);  // wait out the registered reply, with margin
    set_capacity(value);
    if (long) begin
      for (i = 0; i < MAX_BURST + 2; i++) begin
        issue(cmd(OP_WRITE, $urandom_range(0, 255), 0, $urandom_range(0, 127)), 0, '0);
        gap(quiet);
      end
      issue(cmd(OP_READ, $urandom_range(0, 255), 0, 127), 0, '0);
      gap(quiet);
    end
    target = requests_sent + budget;
    while (requests_sent < target) random_sequence(quiet);
  endtask

  // ---------------------------------------------------------------------------
  // Directed plan, run at the reset capacity
  // ---------------------------------------------------------------------------
  typedef struct {
    req_t rq;
    bit   typed;
    rsp_t want;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic void add_row(input req_t rq, input bit typed, input rsp_t want);
    plan_row_t row;
    row.rq    = rq;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endfunction

  initial begin : stimulus
    rsp_t idle_reply;
    idle_reply = status_of(0, 0, 0, 0, 1, 0, 0, 1, 0);

    // empty buffer: reads with and without a count, discard, clear
    add_row(cmd(OP_READ, 0, 0, 1), 1, idle_reply);
    add_row(cmd(OP_READ, 'hFF, 1, 0), 1, idle_reply);
    add_row(cmd(OP_DISCARD, 0, 0, 127), 1, idle_reply);
    add_row(cmd(OP_CLEAR, 0, 0, 1), 1, idle_reply);
    // writes at the byte extremes, write_last echoed, count ignored
    add_row(cmd(OP_WRITE, 'h00, 0, 0), 1, status_of(0, 0, 1, 0, 0, 1, 0, 0, 1));
    add_row(cmd(OP_WRITE, 'hFF, 1, 127), 1, status_of(0, 0, 1, 0, 1, 2, 0, 0, 2));
    add_row(cmd(OP_WRITE, 'h5A, 0, 64), 1, status_of(0, 0, 1, 0, 0, 3, 0, 0, 3));
    add_row(cmd(OP_WRITE, 'hA5, 1, 1), 1, status_of(0, 0, 1, 0, 1, 4, 0, 0, 4));
    // zero count with data held pops nothing
    add_row(cmd(OP_READ, 0, 0, 0), 1, status_of(0, 0, 0, 0, 1, 4, 0, 0, 4));
    add_row(cmd(OP_READ, 0, 0, 2), 0, '0);
    add_row(cmd(OP_DISCARD, 0, 0, 1), 0, '0);
    add_row(cmd(OP_READ, 0, 1, 64), 0, '0);   // pops the rest, empties
    add_row(cmd(OP_READ, 0, 0, 65), 1, idle_reply);
    add_row(cmd(OP_WRITE, 'h80, 1, 3), 0, '0);
    add_row(cmd(OP_WRITE, 'h01, 0, 5), 0, '0);
    add_row(cmd(OP_DISCARD, 0, 0, 64), 0, '0); // discard that empties the ring
    add_row(cmd(OP_WRITE, 'h7F, 1, 0), 0, '0);
    add_row(cmd(OP_CLEAR, 'hFF, 1, 0), 1, idle_reply);
    add_row(cmd(OP_WRITE, 'h3C, 0, 2), 1, status_of(0, 0, 1, 0, 0, 1, 0, 0, 1));
    add_row(cmd(OP_WRITE, 'hC3, 1, 127), 0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      issue(plan[i].rq, plan[i].typed, plan[i].want);
      gap(0);
    end

    // capacity write while bytes are held: must be ignored
    run_phase(7, 1, 0, 1, 0);
    // zero saturates up to a single slot
    run_phase(0, 1, 0, 0, 0);
    run_phase(3, 1, 0, 0, 0);
    // all ones saturates down to DEPTH
    run_phase(2047, 1, 0, 0, 0);
    run_phase($urandom_range(2, 40), 1, 0, 0, 0);
    // closing stretch at full depth, requests back to back, fill past MAX_BURST
    run_phase(DEPTH, 1, 1, 0, 1);

    settle();
    repeat (4) @(posedge clk);

    $display("ran %0d requests, checked %0d replies over %0d capacity writes",
             requests_sent, replies_checked, settings_used);
    $display("capacities 1 to %0d, out-of-range and ignored writes, reads past %0d",
             DEPTH, MAX_BURST);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cbb_pkg.sv
rtl/circular_byte_buffer.sv
rtl/cbb_checker.sv
tb/circular_byte_buffer_test.sv
